@@ design/iso_wk_pkg.sv @@
// Constants, a step type and long-division step functions for the ISO week-of-year pipeline.
package iso_wk_pkg;

    // Microsecond path: |value| is split as (|value| >> US_SHIFT), divided by US_DIV,
    // and the low bits are reattached to the remainder.  86400 * 1000000 = US_DIV << US_SHIFT.
    localparam int US_SHIFT   = 13;
    localparam longint unsigned US_DIV = 64'd86400000000 >> US_SHIFT;
    localparam longint unsigned US_ROUND = 64'd1000000;
    localparam int US_REM_W   = $clog2(US_DIV);
    localparam int MAG_W      = 64;
    localparam int MAG_HI_W   = MAG_W - US_SHIFT;
    localparam int US_STAGES  = (MAG_HI_W + 7) / 8;
    localparam int US_NUM_W   = 8 * US_STAGES;
    // The day quotient of a 64-bit microsecond count never exceeds 27 bits.
    localparam int US_QW      = 27;
    localparam int BIG_R_W    = US_REM_W + US_SHIFT;

    // Calendar constants.
    localparam longint unsigned ERA_DAYS    = 64'd146097;
    localparam longint unsigned EPOCH_SHIFT = 64'd719468;
    localparam longint unsigned ERA_OFF     = ((64'd1 << 31) / ERA_DAYS + 2) * ERA_DAYS;
    localparam longint unsigned W_OFF       = ERA_OFF + 3;
    localparam longint unsigned SHIFT_MOD   = EPOCH_SHIFT % ERA_DAYS;
    localparam int DAY_W        = 32;
    localparam int W_W          = DAY_W + 1;
    localparam int ERA_REM_W    = $clog2(ERA_DAYS);
    localparam int ERA_STAGES   = (W_W + 7) / 8;
    localparam int ERA_NUM_W    = 8 * ERA_STAGES;
    localparam int DOE_W        = ERA_REM_W;
    localparam int YOE_W        = 9;
    localparam int DOY_W        = 9;
    localparam int WEEK_W       = 6;
    localparam int DAYS_WEEK    = 7;
    localparam int DAYS_YEAR    = 365;
    localparam int CENTURY_YRS  = 100;
    localparam int DAYS_4Y      = 1460;
    localparam int DAYS_100Y    = 36524;
    localparam int MAR_TO_JAN   = 306;
    localparam int JAN_TO_MAR   = 59;

    // Reciprocal multipliers: floor(n / d) = (n * M) >> S for n < 2**N,
    // with S = N + clog2(d) and M = ceil(2**S / d).
    localparam int D1460_S  = DOE_W + $clog2(DAYS_4Y);
    localparam longint unsigned D1460_M = ((64'd1 << D1460_S) + DAYS_4Y - 1) / DAYS_4Y;
    localparam int D1460_PW = DOE_W + $clog2(D1460_M + 1);

    localparam int D365_S   = DOE_W + $clog2(DAYS_YEAR);
    localparam longint unsigned D365_M = ((64'd1 << D365_S) + DAYS_YEAR - 1) / DAYS_YEAR;
    localparam int D365_PW  = DOE_W + $clog2(D365_M + 1);

    localparam int E7_S     = DOE_W + $clog2(DAYS_WEEK);
    localparam longint unsigned E7_M = ((64'd1 << E7_S) + DAYS_WEEK - 1) / DAYS_WEEK;
    localparam int E7_PW    = DOE_W + $clog2(E7_M + 1);
    localparam int Q7_W     = 15;

    localparam int D100_S   = YOE_W + $clog2(CENTURY_YRS);
    localparam longint unsigned D100_M = ((64'd1 << D100_S) + CENTURY_YRS - 1) / CENTURY_YRS;
    localparam int D100_PW  = YOE_W + $clog2(D100_M + 1);

    localparam int W7_S     = DOY_W + $clog2(DAYS_WEEK);
    localparam longint unsigned W7_M = ((64'd1 << W7_S) + DAYS_WEEK - 1) / DAYS_WEEK;
    localparam int W7_PW    = DOY_W + $clog2(W7_M + 1);

    // Pipeline stage map: input, microsecond division, day select, offset,
    // era modulo, weekday quotient, day of era, then six calendar stages.
    localparam int ST_DOE   = 1 + US_STAGES + 2 + ERA_STAGES + 1;
    localparam int NSTAGE   = ST_DOE + 7;

    typedef struct packed {
        logic [7:0]          q;
        logic [US_REM_W-1:0] rem;
    } us_step_t;

    // One byte of restoring long division by US_DIV.
    function automatic us_step_t us_div_step(input logic [US_REM_W-1:0] rem_in,
                                             input logic [7:0] chunk);
        logic [US_REM_W:0]   t;
        logic [US_REM_W-1:0] r;
        logic [7:0]          q;
        us_step_t            res;
        r = rem_in;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {r, chunk[i]};
            if (t >= (US_REM_W + 1)'(US_DIV)) begin
                t = t - (US_REM_W + 1)'(US_DIV);
                q[i] = 1'b1;
            end
            r = t[US_REM_W-1:0];
        end
        res.q = q;
        res.rem = r;
        return res;
    endfunction

    // One byte of remainder-only long division by the 400-year cycle length.
    function automatic logic [ERA_REM_W-1:0] era_mod_step(input logic [ERA_REM_W-1:0] rem_in,
                                                          input logic [7:0] chunk);
        logic [ERA_REM_W:0]   t;
        logic [ERA_REM_W-1:0] r;
        r = rem_in;
        for (int i = 7; i >= 0; i--) begin
            t = {r, chunk[i]};
            if (t >= (ERA_REM_W + 1)'(ERA_DAYS)) begin
                t = t - (ERA_REM_W + 1)'(ERA_DAYS);
            end
            r = t[ERA_REM_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/iso_week_of_year.sv @@
// ISO 8601 week number of a day count or a microsecond timestamp, as a 23-stage pipeline.
// An item taken during a stall waits in the input skid register until the pipeline moves again.
// Throughput is one item per cycle while the output does not stall: every stage, including each
// byte-per-stage long division (seven stages for microseconds to days, five for the 400-year cycle),
// takes a new item per cycle whenever the pipeline moves.
// Reset clears the stage valid bits and the skid valid bit; there is no clearing pass.
module iso_week_of_year (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [1:0]  s_tuser,   // [0] command, [1] input_null
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] week, [7:6] zero
    output logic        m_tuser    // [0] result_null
);

    localparam int NS        = iso_wk_pkg::NSTAGE;
    localparam int US_ST     = iso_wk_pkg::US_STAGES;
    localparam int US_NW     = iso_wk_pkg::US_NUM_W;
    localparam int US_RW     = iso_wk_pkg::US_REM_W;
    localparam int US_QW     = iso_wk_pkg::US_QW;
    localparam int LO_W      = iso_wk_pkg::US_SHIFT;
    localparam int BR_W      = iso_wk_pkg::BIG_R_W;
    localparam int DAY_W     = iso_wk_pkg::DAY_W;
    localparam int W_W       = iso_wk_pkg::W_W;
    localparam int ER_ST     = iso_wk_pkg::ERA_STAGES;
    localparam int ER_NW     = iso_wk_pkg::ERA_NUM_W;
    localparam int ER_RW     = iso_wk_pkg::ERA_REM_W;
    localparam int DOE_W     = iso_wk_pkg::DOE_W;
    localparam int YOE_W     = iso_wk_pkg::YOE_W;
    localparam int DOY_W     = iso_wk_pkg::DOY_W;
    localparam int WEEK_W    = iso_wk_pkg::WEEK_W;
    localparam int Q7_W      = iso_wk_pkg::Q7_W;

    typedef struct packed {
        logic             neg;
        logic             cmd;
        logic [DAY_W-1:0] day;
        logic [LO_W-1:0]  lo;
    } us_side_t;

    // ---------------- handshake and skid register ----------------
    logic          en;
    logic          s_xfer;
    logic          in_valid;
    logic [63:0]   in_value;
    logic [1:0]    in_user;
    logic          skid_valid_reg, skid_valid_next;
    logic [63:0]   skid_value_reg, skid_value_next;
    logic [1:0]    skid_user_reg, skid_user_next;
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] nul_reg, nul_next;

    assign s_tready = !skid_valid_reg;
    assign en       = !vld_reg[NS-1] || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid        = skid_valid_reg || s_xfer;
        in_value        = skid_valid_reg ? skid_value_reg : s_tdata;
        in_user         = skid_valid_reg ? skid_user_reg : s_tuser;
        // A transfer taken while the pipeline is stalled parks in the skid register.
        skid_valid_next = en ? 1'b0 : (skid_valid_reg || s_xfer);
        skid_value_next = skid_valid_reg ? skid_value_reg : s_tdata;
        skid_user_next  = skid_valid_reg ? skid_user_reg : s_tuser;
        vld_next        = {vld_reg[NS-2:0], in_valid};
        nul_next        = {nul_reg[NS-2:0], in_user[1]};
    end

    // ---------------- stage A: magnitude ----------------
    logic [63:0]      mag;
    logic [US_NW-1:0] num_reg [0:US_ST-1];
    logic [US_NW-1:0] num_next [0:US_ST-1];
    us_side_t         side_reg [0:US_ST];
    us_side_t         side_next [0:US_ST];

    assign mag          = in_value[63] ? (~in_value + 64'd1) : in_value;
    assign num_next[0]  = US_NW'(mag[63:LO_W]);
    assign side_next[0] = '{neg: in_value[63], cmd: in_user[0],
                            day: in_value[DAY_W-1:0], lo: mag[LO_W-1:0]};

    // ---------------- stages D: |value| / 86400000000, a byte per stage ----------------
    logic [US_RW-1:0] rem_reg [0:US_ST-1];
    logic [US_RW-1:0] rem_next [0:US_ST-1];
    logic [US_QW-1:0] quo_reg [0:US_ST-1];
    logic [US_QW-1:0] quo_next [0:US_ST-1];

    for (genvar k = 0; k < US_ST; k++) begin : g_us
        logic [US_RW-1:0]     rem_in;
        logic [US_QW-1:0]     quo_in;
        iso_wk_pkg::us_step_t step;
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end
        assign step         = iso_wk_pkg::us_div_step(rem_in, num_reg[k][US_NW-1 -: 8]);
        assign rem_next[k]  = step.rem;
        assign quo_next[k]  = {quo_in[US_QW-9:0], step.q};
        assign side_next[k+1] = side_reg[k];
        if (k < US_ST - 1) begin : g_shift
            assign num_next[k+1] = num_reg[k] << 8;
        end
    end

    // ---------------- stage E: day number ----------------
    logic [BR_W-1:0]  big_r;
    logic             rnd;
    logic [DAY_W-1:0] day_us;
    logic [DAY_W-1:0] day_reg, day_next;
    us_side_t         side_e;

    always_comb begin
        side_e = side_reg[US_ST];
        big_r  = {rem_reg[US_ST-1], side_e.lo};
        // A negative count rounds toward minus infinity once at least one whole second remains.
        rnd    = big_r >= BR_W'(iso_wk_pkg::US_ROUND);
        day_us = side_e.neg ? (DAY_W'(0) - (DAY_W'(quo_reg[US_ST-1]) + DAY_W'(rnd)))
                            : DAY_W'(quo_reg[US_ST-1]);
        day_next = side_e.cmd ? day_us : side_e.day;
    end

    // ---------------- stage G and stages M: (day + 3) mod 146097 ----------------
    logic [W_W-1:0]   wsum;
    logic [ER_NW-1:0] wnum_reg [0:ER_ST-1];
    logic [ER_NW-1:0] wnum_next [0:ER_ST-1];
    logic [ER_RW-1:0] erem_reg [0:ER_ST-1];
    logic [ER_RW-1:0] erem_next [0:ER_ST-1];

    // Apart from the +3, the offset is a whole number of 400-year cycles, so it keeps both residues.
    assign wsum         = {day_reg[DAY_W-1], day_reg} + W_W'(iso_wk_pkg::W_OFF);
    assign wnum_next[0] = ER_NW'(wsum);

    for (genvar k = 0; k < ER_ST; k++) begin : g_era
        logic [ER_RW-1:0] rem_in;
        if (k == 0) begin : g_first
            assign rem_in = '0;
        end else begin : g_rest
            assign rem_in = erem_reg[k-1];
        end
        assign erem_next[k] = iso_wk_pkg::era_mod_step(rem_in, wnum_reg[k][ER_NW-1 -: 8]);
        if (k < ER_ST - 1) begin : g_shift
            assign wnum_next[k+1] = wnum_reg[k] << 8;
        end
    end

    // ---------------- stage Q7: quotient by seven ----------------
    logic [iso_wk_pkg::E7_PW-1:0] e7_prod;
    logic [ER_RW-1:0]             e_reg, e_next;
    logic [Q7_W-1:0]              q7_reg, q7_next;

    always_comb begin
        e_next  = erem_reg[ER_ST-1];
        e7_prod = iso_wk_pkg::E7_PW'(e_next) * iso_wk_pkg::E7_PW'(iso_wk_pkg::E7_M);
        q7_next = Q7_W'(e7_prod >> iso_wk_pkg::E7_S);
    end

    // ---------------- stage DOE: day of era of the week's Thursday ----------------
    logic [ER_RW-1:0] r7;
    logic [ER_RW:0]   t_doe;
    logic [DOE_W-1:0] doe_reg, doe_next;

    always_comb begin
        r7    = e_reg - ER_RW'(ER_RW'(q7_reg) * ER_RW'(iso_wk_pkg::DAYS_WEEK));
        t_doe = (ER_RW + 1)'(e_reg) - (ER_RW + 1)'(r7)
              + (ER_RW + 1)'(iso_wk_pkg::SHIFT_MOD);
        doe_next = (t_doe >= (ER_RW + 1)'(iso_wk_pkg::ERA_DAYS))
                 ? DOE_W'(t_doe - (ER_RW + 1)'(iso_wk_pkg::ERA_DAYS))
                 : DOE_W'(t_doe);
    end

    // ---------------- stage C1: leap-corrected day count ----------------
    logic [iso_wk_pkg::D1460_PW-1:0] c1_prod;
    logic [2:0]                      c1_cent;
    logic [DOE_W:0]                  c1_sum;
    logic [DOE_W-1:0]                n_reg, n_next;
    logic [DOE_W-1:0]                doe1_reg, doe1_next;

    always_comb begin
        c1_prod = iso_wk_pkg::D1460_PW'(doe_reg) * iso_wk_pkg::D1460_PW'(iso_wk_pkg::D1460_M);
        c1_cent = 3'(doe_reg >= DOE_W'(iso_wk_pkg::DAYS_100Y))
                + 3'(doe_reg >= DOE_W'(2 * iso_wk_pkg::DAYS_100Y))
                + 3'(doe_reg >= DOE_W'(3 * iso_wk_pkg::DAYS_100Y))
                + 3'(doe_reg >= DOE_W'(4 * iso_wk_pkg::DAYS_100Y));
        c1_sum  = (DOE_W + 1)'(doe_reg)
                - (DOE_W + 1)'(c1_prod >> iso_wk_pkg::D1460_S)
                + (DOE_W + 1)'(c1_cent)
                - (DOE_W + 1)'(doe_reg == DOE_W'(iso_wk_pkg::ERA_DAYS - 1));
        n_next    = c1_sum[DOE_W-1:0];
        doe1_next = doe_reg;
    end

    // ---------------- stage C2: year of era ----------------
    logic [iso_wk_pkg::D365_PW-1:0] c2_prod;
    logic [YOE_W-1:0]               yoe_reg, yoe_next;
    logic [DOE_W-1:0]               doe2_reg, doe2_next;

    always_comb begin
        c2_prod   = iso_wk_pkg::D365_PW'(n_reg) * iso_wk_pkg::D365_PW'(iso_wk_pkg::D365_M);
        yoe_next  = YOE_W'(c2_prod >> iso_wk_pkg::D365_S);
        doe2_next = doe1_reg;
    end

    // ---------------- stage C3: days before the year starts ----------------
    logic [iso_wk_pkg::D100_PW-1:0] c3_prod;
    logic [1:0]                     q100_reg, q100_next;
    logic [DOE_W-1:0]               p_reg, p_next;
    logic [YOE_W-1:0]               yoe3_reg, yoe3_next;
    logic [DOE_W-1:0]               doe3_reg, doe3_next;

    always_comb begin
        c3_prod   = iso_wk_pkg::D100_PW'(yoe_reg) * iso_wk_pkg::D100_PW'(iso_wk_pkg::D100_M);
        q100_next = 2'(c3_prod >> iso_wk_pkg::D100_S);
        p_next    = DOE_W'(DOE_W'(yoe_reg) * DOE_W'(iso_wk_pkg::DAYS_YEAR))
                  + DOE_W'(yoe_reg >> 2);
        yoe3_next = yoe_reg;
        doe3_next = doe2_reg;
    end

    // ---------------- stage C4: March-based day of year and leap flag ----------------
    logic [DOY_W-1:0] doym_reg, doym_next;
    logic             leap_reg, leap_next;

    always_comb begin
        doym_next = DOY_W'(doe3_reg - (p_reg - DOE_W'(q100_reg)));
        // The era year itself is a multiple of 400, so year zero of the era is always leap.
        leap_next = (yoe3_reg[1:0] == 2'b00)
                 && ((yoe3_reg != YOE_W'(YOE_W'(q100_reg) * YOE_W'(iso_wk_pkg::CENTURY_YRS)))
                     || (yoe3_reg == '0));
    end

    // ---------------- stage C5: January-based day of year ----------------
    logic [DOY_W-1:0] doy_reg, doy_next;

    always_comb begin
        if (doym_reg >= DOY_W'(iso_wk_pkg::MAR_TO_JAN)) begin
            doy_next = doym_reg - DOY_W'(iso_wk_pkg::MAR_TO_JAN);
        end else begin
            doy_next = doym_reg + DOY_W'(iso_wk_pkg::JAN_TO_MAR) + DOY_W'(leap_reg);
        end
    end

    // ---------------- stage C6: week number ----------------
    logic [iso_wk_pkg::W7_PW-1:0] c6_prod;
    logic [WEEK_W-1:0]            week_reg, week_next;

    always_comb begin
        c6_prod   = iso_wk_pkg::W7_PW'(doy_reg) * iso_wk_pkg::W7_PW'(iso_wk_pkg::W7_M);
        week_next = nul_reg[NS-2] ? '0
                  : WEEK_W'(c6_prod >> iso_wk_pkg::W7_S) + WEEK_W'(1);
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            vld_reg        <= '0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            if (en) begin
                vld_reg <= vld_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        skid_value_reg <= skid_value_next;
        skid_user_reg  <= skid_user_next;
        if (en) begin
            nul_reg <= nul_next;
            for (int k = 0; k < US_ST; k++) begin
                num_reg[k] <= num_next[k];
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 0; k <= US_ST; k++) begin
                side_reg[k] <= side_next[k];
            end
            day_reg <= day_next;
            for (int k = 0; k < ER_ST; k++) begin
                wnum_reg[k] <= wnum_next[k];
                erem_reg[k] <= erem_next[k];
            end
            e_reg    <= e_next;
            q7_reg   <= q7_next;
            doe_reg  <= doe_next;
            n_reg    <= n_next;
            doe1_reg <= doe1_next;
            yoe_reg  <= yoe_next;
            doe2_reg <= doe2_next;
            q100_reg <= q100_next;
            p_reg    <= p_next;
            yoe3_reg <= yoe3_next;
            doe3_reg <= doe3_next;
            doym_reg <= doym_next;
            leap_reg <= leap_next;
            doy_reg  <= doy_next;
            week_reg <= week_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {(8 - WEEK_W)'(0), week_reg};
    assign m_tuser  = nul_reg[NS-1];

    // ---------------- assertions ----------------
    a_null_week: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("null result carries a nonzero week");

    a_week_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[WEEK_W-1:0] != '0) && (m_tdata[WEEK_W-1:0] <= 6'd53))
        else $error("week number out of range");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved while stalled");

    a_skid_catch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !en |=> skid_valid_reg)
        else $error("transfer during a stall was not held in the skid register");

    a_doe_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[iso_wk_pkg::ST_DOE] |-> doe_reg < DOE_W'(iso_wk_pkg::ERA_DAYS))
        else $error("day of era out of range");

endmodule

@@ test/tb_iso_week_of_year.sv @@
// Self-checking stream testbench for the ISO week-of-year pipeline.
`timescale 1ns / 1ps

module tb_iso_week_of_year;

    localparam bit CMD_DAYS   = 1'b0;
    localparam bit CMD_MICROS = 1'b1;
    // Directed rows either carry their expected week or defer to the predictor.
    localparam bit EXP_MODEL  = 1'b0;
    localparam bit EXP_TABLE  = 1'b1;

    localparam longint DAYS_400Y     = 146097;
    localparam longint SHIFT_0301    = 719468;
    localparam longint USEC_PER_SEC  = 1000000;
    localparam longint SEC_PER_DAY   = 86400;
    localparam longint USEC_PER_DAY  = 64'sd86400000000;

    localparam int NUM_RANDOM   = 500;
    localparam int HOLD_AT      = 40;
    localparam int BURST_END    = 140;
    localparam int DRAIN_AT     = 300;
    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 30;

    typedef struct packed {
        logic [5:0] week;
        logic       is_null;
    } week_res_t;

    typedef struct packed {
        bit        cmd;
        bit [63:0] value;
        bit        in_null;
        bit        how;
        bit [5:0]  week;
        bit        res_null;
    } dir_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam dir_row_t DIR_TAB [NUM_DIRECTED] = '{
        // The epoch is a Thursday, so it falls in week 1.
        '{CMD_DAYS,   64'd0,                    1'b0, EXP_TABLE, 6'd1, 1'b0},
        '{CMD_MICROS, 64'd0,                    1'b0, EXP_TABLE, 6'd1, 1'b0},
        // Small negative microsecond counts truncate to second 0, not -1.
        '{CMD_MICROS, -64'sd1,                  1'b0, EXP_TABLE, 6'd1, 1'b0},
        '{CMD_MICROS, -64'sd999999,             1'b0, EXP_TABLE, 6'd1, 1'b0},
        '{CMD_MICROS, -64'sd1000000,            1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   64'h0000_0000_7FFF_FFFF,  1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   64'h0000_0000_8000_0000,  1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   64'hFFFF_FFFF_FFFF_FFFF,  1'b0, EXP_MODEL, 6'd0, 1'b0},
        // Upper word is ignored in day mode.
        '{CMD_DAYS,   64'hDEAD_BEEF_0000_0000,  1'b0, EXP_TABLE, 6'd1, 1'b0},
        '{CMD_DAYS,   64'hFFFF_FFFF_7FFF_FFFF,  1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_MICROS, 64'h7FFF_FFFF_FFFF_FFFF,  1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_MICROS, 64'h8000_0000_0000_0000,  1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   64'd0,                    1'b1, EXP_TABLE, 6'd0, 1'b1},
        '{CMD_MICROS, 64'h7FFF_FFFF_FFFF_FFFF,  1'b1, EXP_TABLE, 6'd0, 1'b1},
        '{CMD_DAYS,   64'hFFFF_FFFF_FFFF_FFFF,  1'b1, EXP_TABLE, 6'd0, 1'b1},
        '{CMD_MICROS, 64'h8000_0000_0000_0000,  1'b1, EXP_TABLE, 6'd0, 1'b1},
        // Around the turn of 2020/2021, a year with 53 weeks.
        '{CMD_DAYS,   64'd18627,                1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   64'd18630,                1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   64'd18631,                1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   64'd3,                    1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   64'd4,                    1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   -64'sd3,                  1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_DAYS,   -64'sd4,                  1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_MICROS, 64'sd86399999999,         1'b0, EXP_MODEL, 6'd0, 1'b0},
        '{CMD_MICROS, -64'sd86400000001,        1'b0, EXP_MODEL, 6'd0, 1'b0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;   // [0] command, [1] input_null
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [5:0] week, [7:6] zero
    logic        m_tuser;   // [0] result_null

    week_res_t pending_weeks[$];
    int        err_count;
    bit        hold_req;

    iso_week_of_year uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic longint div_floor(input longint a, input longint b);
        longint q;
        q = a / b;
        if (a < 0 && (a % b) != 0) begin
            q--;
        end
        return q;
    endfunction

    // Monday = 1 .. Sunday = 7.
    function automatic longint weekday_of(input longint d);
        return (d + 3) - div_floor(d + 3, 7) * 7 + 1;
    endfunction

    // Civil year of a day count, counted in eras that start on March 1.
    function automatic longint year_of(input longint d);
        longint z, era, doe, yoe, doy, mp, y;
        z   = d + SHIFT_0301;
        era = div_floor(z, DAYS_400Y);
        doe = z - era * DAYS_400Y;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        y   = yoe + era * 400;
        if (mp >= 10) begin
            y++;
        end
        return y;
    endfunction

    function automatic longint jan4_of(input longint year);
        longint y, era, yoe, doe;
        y   = year - 1;
        era = div_floor(y, 400);
        yoe = y - era * 400;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + 309;
        return era * DAYS_400Y + doe - SHIFT_0301;
    endfunction

    function automatic week_res_t calc_iso_week(input bit cmd, input logic [63:0] val,
                                                input bit in_null);
        week_res_t res;
        longint    day, secs, thu, j4, thu1, w;
        res = '0;
        if (in_null) begin
            res.is_null = 1'b1;
            return res;
        end
        if (cmd == CMD_DAYS) begin
            day = $signed(val[31:0]);
        end else begin
            secs = $signed(val) / USEC_PER_SEC;
            day  = div_floor(secs, SEC_PER_DAY);
        end
        thu  = day - (weekday_of(day) - 4);
        j4   = jan4_of(year_of(thu));
        thu1 = j4 - (weekday_of(j4) - 4);
        w    = div_floor(thu - thu1, 7) + 1;
        res.week = w[5:0];
        return res;
    endfunction

    task automatic send_item(input bit cmd, input logic [63:0] val, input bit in_null,
                             input week_res_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= {in_null, cmd};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        pending_weeks.push_back(want);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_weeks.size() != 0) @(posedge aclk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Source side: directed table, then random items.
    initial begin : source
        bit          cmd, in_null;
        logic [63:0] val;
        longint      day, ofs;
        int          kind;
        week_res_t   want;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        err_count = 0;
        hold_req  = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (DIR_TAB[i].how == EXP_TABLE) begin
                want.week    = DIR_TAB[i].week;
                want.is_null = DIR_TAB[i].res_null;
            end else begin
                want = calc_iso_week(DIR_TAB[i].cmd, DIR_TAB[i].value, DIR_TAB[i].in_null);
            end
            send_item(DIR_TAB[i].cmd, DIR_TAB[i].value, DIR_TAB[i].in_null, want);
            idle_sender(pick_gap());
        end
        drain_results();

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == HOLD_AT) begin
                hold_req = 1'b1;
            end
            if (i == DRAIN_AT) begin
                drain_results();
            end
            kind    = $urandom_range(0, 99);
            in_null = 1'b0;
            if (kind < 10) begin
                cmd     = $urandom_range(0, 1);
                val     = {$urandom, $urandom};
                in_null = 1'b1;
            end else if (kind < 35) begin
                // A few days either side of a year's first Thursday week.
                cmd = CMD_DAYS;
                day = jan4_of(longint'($urandom_range(0, 6000)) - 3000)
                      + longint'($urandom_range(0, 16)) - 10;
                val = {$urandom, day[31:0]};
            end else if (kind < 55) begin
                cmd = CMD_DAYS;
                val = {$urandom, $urandom};
            end else if (kind < 75) begin
                cmd = CMD_MICROS;
                val = {$urandom, $urandom};
            end else begin
                // Near midnight, where truncation and flooring part ways for negatives.
                cmd = CMD_MICROS;
                day = longint'($urandom_range(0, 32'h0800_0000)) - 64'sh0400_0000;
                ofs = longint'($urandom_range(0, 2000002)) - 1000001;
                val = day * USEC_PER_DAY + ofs;
            end
            send_item(cmd, val, in_null, calc_iso_week(cmd, val, in_null));
            if (i < HOLD_AT || i >= BURST_END) begin
                idle_sender(pick_gap());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Sink side: random back-pressure, with one long hold-off that fills the pipeline.
    initial begin : sink
        int run_left, stall_left, r;
        bit hold_done;
        m_tready   = 1'b0;
        run_left   = 0;
        stall_left = 0;
        hold_done  = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                run_left   = 0;
            end
            if (stall_left == 0 && run_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    stall_left = 0;
                end else if (r < 88) begin
                    stall_left = $urandom_range(1, 3);
                end else begin
                    stall_left = $urandom_range(8, 40);
                end
                run_left = $urandom_range(1, 24);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                run_left--;
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_result
        week_res_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_weeks.size() == 0) begin
                $error("unexpected result transfer: week %0d result_null %0b",
                       m_tdata[5:0], m_tuser);
                err_count++;
            end else begin
                want = pending_weeks.pop_front();
                if (m_tdata[5:0] !== want.week) begin
                    $error("week: expected %0d, actual %0d", want.week, m_tdata[5:0]);
                    err_count++;
                end
                if (m_tdata[7:6] !== 2'b00) begin
                    $error("tdata padding: expected 0, actual %0d", m_tdata[7:6]);
                    err_count++;
                end
                if (m_tuser !== want.is_null) begin
                    $error("result_null: expected %0b, actual %0b", want.is_null, m_tuser);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
